### src/ordq_pkg.sv
// ----------------------------------------------------------------------------
// ordq_pkg
// Shared types and constants for the overwriting ring deque: operation codes,
// request and response payloads, and the status carried down the pipeline.
// ----------------------------------------------------------------------------
package ordq_pkg;

    localparam int DEPTH_DEFAULT      = 8;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int FUNC_WIDTH  = 3;
    localparam int VALUE_WIDTH = 32;
    localparam int INDEX_WIDTH = 3;
    localparam int COUNT_WIDTH = 4;

    localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_REAR  = 3'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_WIDTH-1:0] FUNC_READ       = 3'd4;
    localparam logic [FUNC_WIDTH-1:0] FUNC_CLEAR      = 3'd5;

    typedef struct packed {
        logic [FUNC_WIDTH-1:0]  func;
        logic [VALUE_WIDTH-1:0] data_in;
        logic [INDEX_WIDTH-1:0] read_index;
    } req_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] read_value;
        logic [COUNT_WIDTH-1:0] item_count;
        logic                   is_full;
        logic                   is_empty;
        logic                   index_out_of_range;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] item_count;
        logic                   is_full;
        logic                   is_empty;
        logic                   index_out_of_range;
        logic                   read_hit;
    } status_t;

endpackage

### src/ordq_ram.sv
// ----------------------------------------------------------------------------
// ordq_ram
// Generic single-clock RAM with one write port and one read port; the read
// data is registered and holds while the read enable is low.
// ----------------------------------------------------------------------------
module ordq_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ordq_ctrl.sv
// ----------------------------------------------------------------------------
// ordq_ctrl
// Front pointer and element count of the deque. For each processed request
// it works out the slot to write or read and the status after the operation.
// ----------------------------------------------------------------------------
module ordq_ctrl
    import ordq_pkg::*;
#(
    parameter int  DEPTH      = DEPTH_DEFAULT,
    parameter int  DATA_WIDTH = DATA_WIDTH_DEFAULT,
    localparam int PW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  req_t                  op,
    output logic                  we,
    output logic [PW-1:0]         waddr,
    output logic [DATA_WIDTH-1:0] wdata,
    output logic                  re,
    output logic [PW-1:0]         raddr,
    output status_t               status
);

    localparam int SW = PW + 1;
    localparam int IW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;

    logic [PW-1:0] front_reg;
    logic [PW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          is_full_now;
    logic          hit;
    logic          we_op;
    logic          re_op;
    logic [IW-1:0] idx_w;

    // offset must stay below DEPTH, so one conditional subtract wraps it
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [SW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign is_full_now = (count_reg == CW'(DEPTH));
    assign idx_w       = IW'(op.read_index);
    assign hit         = (idx_w < IW'(count_reg));
    assign wdata       = DATA_WIDTH'(op.data_in);
    assign raddr       = wrap_add(front_reg, SW'(idx_w));

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        we_op      = 1'b0;
        re_op      = 1'b0;
        waddr      = front_reg;
        unique case (op.func)
            FUNC_PUSH_REAR:
            begin
                we_op = 1'b1;
                if (is_full_now)
                begin
                    // overwrite the front element and advance past it
                    waddr      = front_reg;
                    front_next = wrap_add(front_reg, SW'(1));
                end
                else
                begin
                    waddr      = wrap_add(front_reg, SW'(count_reg));
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_PUSH_FRONT:
            begin
                we_op      = 1'b1;
                front_next = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - PW'(1);
                waddr      = front_next;
                if (!is_full_now)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_POP_BACK:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_POP_FRONT:
            begin
                if (count_reg != '0)
                begin
                    front_next = wrap_add(front_reg, SW'(1));
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_READ:
            begin
                re_op = hit;
            end
            FUNC_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign we = en && we_op;
    assign re = en && re_op;

    always_comb
    begin
        status.item_count         = COUNT_WIDTH'(count_next);
        status.is_full            = (count_next == CW'(DEPTH));
        status.is_empty           = (count_next == '0);
        status.index_out_of_range = (op.func == FUNC_READ) && !hit;
        status.read_hit           = (op.func == FUNC_READ) && hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

### src/overwriting_ring_deque_top.sv
// ----------------------------------------------------------------------------
// overwriting_ring_deque_top
// Fixed-capacity ring deque with overwrite on full, reads at an offset from
// the front, and a status response for every request.
// ----------------------------------------------------------------------------
// The block accepts one request per cycle while the response side is not
// stalled, and returns exactly one response per request, in order. A request
// is held first in the input register, where the pointer and count update and
// the single slot it touches is written or read through one port of the
// element RAM; the registered RAM read and the status register form the
// response stage. A stalled response holds the pipeline, and the input
// register still takes one more request. Elements are never cleared in the
// RAM: an in-range read only reaches written slots, so no clearing pass runs
// after reset.
module overwriting_ring_deque_top
    import ordq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  s1_valid_reg;
    req_t                  s1_reg;
    logic                  s2_valid_reg;
    status_t               s2_status_reg;
    logic                  adv;
    logic                  proc;
    logic                  ram_we;
    logic [PW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [PW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    status_t               status_next;

    // advance the pipeline whenever the response stage is free or drains
    assign adv       = !s2_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || adv;
    assign proc      = s1_valid_reg && adv;

    ordq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (proc),
        .op     (s1_reg),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr  (ram_raddr),
        .status (status_next)
    );

    ordq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            s1_reg <= req;
        end
        if (proc)
        begin
            s2_status_reg <= status_next;
        end
    end

    assign rsp_valid = s2_valid_reg;

    always_comb
    begin
        rsp.read_value         = s2_status_reg.read_hit ? VALUE_WIDTH'(ram_rdata) : '0;
        rsp.item_count         = s2_status_reg.item_count;
        rsp.is_full            = s2_status_reg.is_full;
        rsp.is_empty           = s2_status_reg.is_empty;
        rsp.index_out_of_range = s2_status_reg.index_out_of_range;
    end

    a_oor_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.index_out_of_range |-> rsp.read_value == '0)
        else $error("out-of-range read returned a nonzero value");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.is_full && rsp.is_empty))
        else $error("response flags full and empty together");

    a_stall_holds_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready && s2_status_reg.read_hit |=> $stable(ram_rdata))
        else $error("read data changed while the response was stalled");

    a_no_ram_access_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> !ram_we && !ram_re)
        else $error("RAM accessed while the pipeline was held");

endmodule

### verif/overwriting_ring_deque_top_test.sv
// ----------------------------------------------------------------------------
// overwriting_ring_deque_top_test
// Self-checking bench for the overwriting ring deque. A local copy of the
// deque state predicts the response to every request transfer. Responses are
// matched in order, field by field. Directed corner cases come first, then
// random traffic with random gaps and stalls on both channels, except in a final back-to-back phase.
// ----------------------------------------------------------------------------
module overwriting_ring_deque_top_test;
    import ordq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1000;

    // Codes with no meaning in the block; they must only report status.
    localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Predicted deque state
    logic [VALUE_WIDTH-1:0] deque_slots [DEPTH];
    logic [INDEX_WIDTH-1:0] deque_front;
    logic [COUNT_WIDTH-1:0] deque_count;

    rsp_t        expected_rsp_q [$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left  = 0;
    bit          gaps_on     = 1'b1;

    overwriting_ring_deque_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH_DEFAULT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Mostly back to back, sometimes short gaps, rarely long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic rsp_t predict_deque(req_t op);
        rsp_t res;
        res = '0;
        case (op.func)
            FUNC_PUSH_REAR:
            begin
                if (deque_count == DEPTH)
                begin
                    // overwrite the front and advance past it
                    deque_slots[deque_front] = op.data_in;
                    deque_front = deque_front + 1'b1;
                end
                else
                begin
                    deque_slots[deque_front + deque_count[INDEX_WIDTH-1:0]] = op.data_in;
                    deque_count = deque_count + 1'b1;
                end
            end
            FUNC_PUSH_FRONT:
            begin
                deque_front = deque_front - 1'b1;
                deque_slots[deque_front] = op.data_in;
                if (deque_count != DEPTH)
                    deque_count = deque_count + 1'b1;
            end
            FUNC_POP_BACK:
            begin
                if (deque_count != 0)
                    deque_count = deque_count - 1'b1;
            end
            FUNC_POP_FRONT:
            begin
                if (deque_count != 0)
                begin
                    deque_front = deque_front + 1'b1;
                    deque_count = deque_count - 1'b1;
                end
            end
            FUNC_READ:
            begin
                if ({1'b0, op.read_index} < deque_count)
                    res.read_value = deque_slots[deque_front + op.read_index];
                else
                    res.index_out_of_range = 1'b1;
            end
            FUNC_CLEAR:
            begin
                deque_front = '0;
                deque_count = '0;
            end
            default:
            begin
            end
        endcase
        res.item_count = deque_count;
        res.is_full    = (deque_count == DEPTH);
        res.is_empty   = (deque_count == 0);
        return res;
    endfunction

    function automatic req_t make_op(logic [FUNC_WIDTH-1:0] func,
                                     logic [VALUE_WIDTH-1:0] data,
                                     logic [INDEX_WIDTH-1:0] index);
        req_t op;
        op.func       = func;
        op.data_in    = data;
        op.read_index = index;
        return op;
    endfunction

    // push_pct steers the fill level: high fills the deque, low drains it.
    function automatic req_t random_deque_op(int unsigned push_pct);
        req_t        op;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            op.data_in = '0;
        else if (roll < 20)
            op.data_in = '1;
        else
            op.data_in = $urandom();
        op.read_index = INDEX_WIDTH'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < push_pct)
            op.func = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                op.func = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
            else if (roll < 93)
                op.func = FUNC_READ;
            else if (roll < 97)
                op.func = FUNC_CLEAR;
            else
                op.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        end
        return op;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    // Valid is left high so a following call can continue without a gap.
    task automatic send_op(req_t op);
        int unsigned gap;
        rsp_t        want;
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= op;
        do
            @(posedge clk);
        while (!req_ready);
        want = predict_deque(op);
        expected_rsp_q = {expected_rsp_q, want};
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(string field, logic [VALUE_WIDTH-1:0] want,
                                 logic [VALUE_WIDTH-1:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    task automatic test_directed();
        // empty deque: pops do nothing, reads miss, spare codes only report
        send_op(make_op(FUNC_POP_BACK, 32'h0, 3'd0));
        send_op(make_op(FUNC_POP_FRONT, 32'h0, 3'd0));
        send_op(make_op(FUNC_READ, 32'h0, 3'd0));
        send_op(make_op(FUNC_SPARE_LO, 32'hFFFF_FFFF, 3'd7));
        send_op(make_op(FUNC_SPARE_HI, 32'h0, 3'd0));
        // fill to capacity with extreme values
        send_op(make_op(FUNC_PUSH_REAR, 32'h0000_0000, 3'd7));
        send_op(make_op(FUNC_PUSH_REAR, 32'hFFFF_FFFF, 3'd0));
        send_op(make_op(FUNC_PUSH_REAR, 32'hAAAA_AAAA, 3'd0));
        send_op(make_op(FUNC_PUSH_REAR, 32'h5555_5555, 3'd0));
        send_op(make_op(FUNC_PUSH_REAR, 32'h0000_0001, 3'd0));
        send_op(make_op(FUNC_PUSH_REAR, 32'h8000_0000, 3'd0));
        send_op(make_op(FUNC_PUSH_REAR, 32'h7FFF_FFFF, 3'd0));
        send_op(make_op(FUNC_PUSH_REAR, 32'hFFFF_FFFE, 3'd0));
        // overwrite on full from both ends
        send_op(make_op(FUNC_PUSH_REAR, 32'h1234_5678, 3'd0));
        send_op(make_op(FUNC_PUSH_FRONT, 32'h9ABC_DEF0, 3'd0));
        send_op(make_op(FUNC_READ, 32'h0, 3'd0));
        send_op(make_op(FUNC_READ, 32'h0, 3'd7));
        // last offset falls out of range once an element is gone
        send_op(make_op(FUNC_POP_BACK, 32'h0, 3'd0));
        send_op(make_op(FUNC_READ, 32'h0, 3'd7));
        send_op(make_op(FUNC_POP_FRONT, 32'h0, 3'd0));
        send_op(make_op(FUNC_CLEAR, 32'h0, 3'd0));
        send_op(make_op(FUNC_READ, 32'h0, 3'd0));
        // push front on empty wraps the front pointer below zero
        send_op(make_op(FUNC_PUSH_FRONT, 32'hC3C3_3C3C, 3'd0));
        send_op(make_op(FUNC_READ, 32'h0, 3'd0));
    endtask

    task automatic test_random_mix(int unsigned n_ops);
        for (int unsigned i = 0; i < n_ops; i++)
            send_op(random_deque_op($urandom_range(30, 60)));
    endtask

    // Fill past capacity, read every offset, then drain past empty.
    task automatic test_fill_drain(int unsigned rounds);
        for (int unsigned r = 0; r < rounds; r++)
        begin
            for (int unsigned i = 0; i < 40; i++)
                send_op(random_deque_op(85));
            for (int unsigned idx = 0; idx < DEPTH; idx++)
                send_op(make_op(FUNC_READ, 32'h0, idx[INDEX_WIDTH-1:0]));
            for (int unsigned i = 0; i < 20; i++)
                send_op(random_deque_op(10));
        end
    endtask

    task automatic test_drain_pause(int unsigned bursts);
        for (int unsigned b = 0; b < bursts; b++)
        begin
            for (int unsigned i = 0; i < 20; i++)
                send_op(random_deque_op(55));
            wait_drained();
        end
    endtask

    task automatic test_back_to_back(int unsigned n_ops);
        gaps_on = 1'b0;
        for (int unsigned i = 0; i < n_ops; i++)
            send_op(random_deque_op($urandom_range(20, 80)));
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        deque_front = '0;
        deque_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(220);
        test_fill_drain(4);
        test_drain_pause(3);
        test_back_to_back(180);

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Check each response transfer and drive random stalls on the response side.
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
                note_mismatch("unexpected response", '0, rsp.read_value);
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.read_value !== want.read_value)
                    note_mismatch("read_value", want.read_value, rsp.read_value);
                if (rsp.item_count !== want.item_count)
                    note_mismatch("item_count", want.item_count, rsp.item_count);
                if (rsp.is_full !== want.is_full)
                    note_mismatch("is_full", want.is_full, rsp.is_full);
                if (rsp.is_empty !== want.is_empty)
                    note_mismatch("is_empty", want.is_empty, rsp.is_empty);
                if (rsp.index_out_of_range !== want.index_out_of_range)
                    note_mismatch("index_out_of_range", want.index_out_of_range,
                                  rsp.index_out_of_range);
            end
        end
        if (stall_left == 0 && gaps_on)
            stall_left = pick_gap();
        if (stall_left != 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

### sim.f
src/ordq_pkg.sv
src/ordq_ram.sv
src/ordq_ctrl.sv
src/overwriting_ring_deque_top.sv
verif/overwriting_ring_deque_top_test.sv
